// ----- hw/rtl/jstc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jstc_pkg
// shared types and codes of the job slot table: operations, run states,
// result status codes, table entry layout and sequencer states
// ----------------------------------------------------------------------------
package jstc_pkg;

   localparam int NUMBER_W = 32;
   localparam int ID_W     = 22;

   // most results one sweep hands out
   localparam int                     SWEEP_CNT_W = 5;
   localparam logic [SWEEP_CNT_W-1:0] MAX_OUT     = 5'd16;

   typedef enum logic [2:0] {
      OP_ADD          = 3'd0,
      OP_SET_STATE    = 3'd1,
      OP_REMOVE       = 3'd2,
      OP_MARK_RUNNING = 3'd3,
      OP_GET_CURRENT  = 3'd4,
      OP_GET_STOPPED  = 3'd5,
      OP_CHILD_EVENT  = 3'd6,
      OP_SWEEP        = 3'd7
   } op_type;

   localparam logic [1:0] RUN_RUNNING = 2'd0;
   localparam logic [1:0] RUN_STOPPED = 2'd1;
   localparam logic [1:0] RUN_DONE    = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_NONE    = 2'd2;
   localparam logic [1:0] STATUS_IGNORED = 2'd3;

   typedef struct packed {
      logic [NUMBER_W-1:0] number;
      logic [ID_W-1:0]     group;
      logic [ID_W-1:0]     process;
      logic [1:0]          state;
   } entry_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [NUMBER_W-1:0] number;
      logic [ID_W-1:0]     group;
      logic [1:0]          state;
      logic [3:0]          slot;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RMW,
      S_CUR,
      S_SCAN,
      S_SW_RD,
      S_SW_EV,
      S_EMIT
   } fsm_type;

   typedef enum logic [1:0] {
      MODE_STOP,
      MODE_PID,
      MODE_MAX
   } scan_type;

endpackage

// ----- hw/rtl/jstc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jstc_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module jstc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/job_slot_table_with_current_mark_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_slot_table_with_current_mark_core
// table of job slots with a current mark, driven one command word at a time
// ----------------------------------------------------------------------------
// usage
//  - req_* carries one command word (add, set state, remove, mark running,
//    get current, get stopped, child event, sweep); it is taken when req_valid
//    is high and req_stall is low. the table works on one word at a time and
//    holds req_stall high until the command, with any rescan, is finished
//  - rsp_* returns result words; rsp_last marks the final word of a command.
//    sweep: a word per removed job (at most 16), or one none word; other commands one
//  - entry payload (number, group, process, run state) sits in one ram with a
//    registered read; valid bits and the current slot are flops
//  - child event, and get stopped without a current job, scan the whole table
//    with one ram read per cycle; get stopped with a current job reads it first
//    and scans only if it is not stopped; remove of the current job adds a
//    rescan for the highest job number, and a sweep adds that rescan whenever
//    it frees the current job
//  - reads are issued only after the previous command's write has landed, so
//    no forwarding is needed on the ram
//  - reset empties the table at once (valid bits and current mark clear, job
//    numbering restarts at 1); the ram is not cleared
//  - when rsp_stall is high the result word holds; a sweep then waits with
//    its next word, and a new command is still taken while the last word waits
// ----------------------------------------------------------------------------
module job_slot_table_with_current_mark_core #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [21:0] req_group_id,
   input  logic [21:0] req_process_id,
   input  logic [1:0]  req_run_state,
   input  logic [4:0]  req_slot_index,
   input  logic        req_terminated,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_job_number,
   output logic [21:0] rsp_group_out,
   output logic [1:0]  rsp_state_out,
   output logic [3:0]  rsp_slot_out,
   output logic        rsp_last
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [CW-1:0] SLOT_END  = CW'(SLOTS);
   localparam logic [6:0]    SLOT_LIM7 = 7'(SLOTS);

   // sequencer
   jstc_pkg::fsm_type  state_ff, state_in;
   jstc_pkg::fsm_type  after_ff, after_in;
   jstc_pkg::op_type   op_ff, op_in;

   // captured command fields
   logic [21:0]        pid_ff, pid_in;
   logic [1:0]         st_ff, st_in;
   logic               term_ff, term_in;
   logic [SW-1:0]      slot_ff, slot_in;

   // table flops
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic               cur_valid_ff, cur_valid_in;
   logic [SW-1:0]      cur_slot_ff, cur_slot_in;
   logic [31:0]        next_number_ff, next_number_in;

   // scan engine
   jstc_pkg::scan_type mode_ff, mode_in;
   logic [CW-1:0]      scan_cnt_ff, scan_cnt_in;
   logic               ev_pend_ff, ev_pend_in;
   logic [SW-1:0]      ev_idx_ff, ev_idx_in;
   logic               best_valid_ff, best_valid_in;
   logic [SW-1:0]      best_idx_ff, best_idx_in;
   jstc_pkg::entry_type best_ent_ff, best_ent_in;
   logic               ret_sweep_ff, ret_sweep_in;

   // sweep walk
   logic [CW-1:0]      sw_idx_ff, sw_idx_in;
   logic [jstc_pkg::SWEEP_CNT_W-1:0] sw_cnt_ff, sw_cnt_in;
   logic               hold_valid_ff, hold_valid_in;

   // pending result (also the held sweep word)
   jstc_pkg::rsp_type  res_ff, res_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   jstc_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_last_ff, rsp_last_in;

   // ram port
   logic               wr_en;
   logic [SW-1:0]      wr_addr;
   jstc_pkg::entry_type wr_data;
   logic               rd_en;
   logic [SW-1:0]      rd_addr;
   jstc_pkg::entry_type rd_data;

   // helpers
   logic               req_accept;
   logic               out_free;
   logic [SW+4:0]      req_ext;
   logic [SW-1:0]      req_slot;
   logic               req_slot_ok;
   logic [1:0]         req_st_sat;
   logic               free_found;
   logic [SW-1:0]      free_idx;
   logic               ev_v;
   logic               ev_hit;
   logic               issue_ok;

   function automatic jstc_pkg::rsp_type rsp_ok(input logic [31:0] number,
                                                input logic [21:0] group,
                                                input logic [1:0]  st,
                                                input logic [SW-1:0] idx);
      jstc_pkg::rsp_type r;
      logic [SW+3:0]     ext;
      ext      = {4'b0000, idx};
      r.status = jstc_pkg::STATUS_OK;
      r.number = number;
      r.group  = group;
      r.state  = st;
      r.slot   = ext[3:0];
      return r;
   endfunction

   function automatic jstc_pkg::rsp_type rsp_bad(input logic [1:0] status);
      jstc_pkg::rsp_type r;
      r        = '0;
      r.status = status;
      return r;
   endfunction

   jstc_ram #(
      .WIDTH  ($bits(jstc_pkg::entry_type)),
      .DEPTH  (SLOTS),
      .ADDR_W (SW)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall  = reset || (state_ff != jstc_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // slot index checks: range against SLOTS, then the valid bit
   assign req_ext     = {{SW{1'b0}}, req_slot_index};
   assign req_slot    = req_ext[SW-1:0];
   assign req_slot_ok = ({2'b00, req_slot_index} < SLOT_LIM7) && valid_ff[req_slot];
   assign req_st_sat  = (req_run_state > jstc_pkg::RUN_DONE) ? jstc_pkg::RUN_DONE
                                                              : req_run_state;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SW'(i);
         end
      end
   end

   // scan compare on the word that came back from the ram
   assign issue_ok = (scan_cnt_ff != SLOT_END);
   assign ev_v     = valid_ff[ev_idx_ff];

   always_comb begin
      case (mode_ff)
         jstc_pkg::MODE_STOP: begin
            ev_hit = ev_v && (rd_data.state == jstc_pkg::RUN_STOPPED) &&
                     (!best_valid_ff || (rd_data.number > best_ent_ff.number));
         end
         jstc_pkg::MODE_PID: begin
            ev_hit = ev_v && (rd_data.process == pid_ff) && !best_valid_ff;
         end
         default: begin
            ev_hit = ev_v && (!best_valid_ff || (rd_data.number > best_ent_ff.number));
         end
      endcase
   end

   // next state and datapath
   always_comb begin
      state_in       = state_ff;
      after_in       = after_ff;
      op_in          = op_ff;
      pid_in         = pid_ff;
      st_in          = st_ff;
      term_in        = term_ff;
      slot_in        = slot_ff;
      valid_in       = valid_ff;
      cur_valid_in   = cur_valid_ff;
      cur_slot_in    = cur_slot_ff;
      next_number_in = next_number_ff;
      mode_in        = mode_ff;
      scan_cnt_in    = scan_cnt_ff;
      ev_pend_in     = ev_pend_ff;
      ev_idx_in      = ev_idx_ff;
      best_valid_in  = best_valid_ff;
      best_idx_in    = best_idx_ff;
      best_ent_in    = best_ent_ff;
      ret_sweep_in   = ret_sweep_ff;
      sw_idx_in      = sw_idx_ff;
      sw_cnt_in      = sw_cnt_ff;
      hold_valid_in  = hold_valid_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = '0;
      rd_en          = 1'b0;
      rd_addr        = '0;

      // result word leaves when the receiver takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         jstc_pkg::S_IDLE: begin
            if (req_accept) begin
               op_in    = jstc_pkg::op_type'(req_operation);
               pid_in   = req_process_id;
               st_in    = req_st_sat;
               term_in  = req_terminated;
               slot_in  = req_slot;
               after_in = jstc_pkg::S_IDLE;
               case (jstc_pkg::op_type'(req_operation))
                  jstc_pkg::OP_ADD: begin
                     state_in = jstc_pkg::S_EMIT;
                     if (!free_found) begin
                        res_in = rsp_bad(jstc_pkg::STATUS_FULL);
                     end else begin
                        wr_en             = 1'b1;
                        wr_addr           = free_idx;
                        wr_data.number    = next_number_ff;
                        wr_data.group     = req_group_id;
                        wr_data.process   = req_process_id;
                        wr_data.state     = req_st_sat;
                        valid_in[free_idx] = 1'b1;
                        cur_valid_in      = 1'b1;
                        cur_slot_in       = free_idx;
                        // numbering sticks at the top value
                        if (next_number_ff != '1) begin
                           next_number_in = next_number_ff + 32'd1;
                        end
                        res_in = rsp_ok(next_number_ff, req_group_id, req_st_sat, free_idx);
                     end
                  end
                  jstc_pkg::OP_SET_STATE, jstc_pkg::OP_REMOVE,
                  jstc_pkg::OP_MARK_RUNNING: begin
                     if (req_slot_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_slot;
                        state_in = jstc_pkg::S_RMW;
                     end else begin
                        res_in   = rsp_bad(jstc_pkg::STATUS_IGNORED);
                        state_in = jstc_pkg::S_EMIT;
                     end
                  end
                  jstc_pkg::OP_GET_CURRENT: begin
                     if (cur_valid_ff) begin
                        rd_en    = 1'b1;
                        rd_addr  = cur_slot_ff;
                        state_in = jstc_pkg::S_CUR;
                     end else begin
                        res_in   = rsp_bad(jstc_pkg::STATUS_NONE);
                        state_in = jstc_pkg::S_EMIT;
                     end
                  end
                  jstc_pkg::OP_GET_STOPPED: begin
                     if (cur_valid_ff) begin
                        rd_en    = 1'b1;
                        rd_addr  = cur_slot_ff;
                        state_in = jstc_pkg::S_CUR;
                     end else begin
                        mode_in       = jstc_pkg::MODE_STOP;
                        scan_cnt_in   = '0;
                        ev_pend_in    = 1'b0;
                        best_valid_in = 1'b0;
                        ret_sweep_in  = 1'b0;
                        state_in      = jstc_pkg::S_SCAN;
                     end
                  end
                  jstc_pkg::OP_CHILD_EVENT: begin
                     mode_in       = jstc_pkg::MODE_PID;
                     scan_cnt_in   = '0;
                     ev_pend_in    = 1'b0;
                     best_valid_in = 1'b0;
                     ret_sweep_in  = 1'b0;
                     state_in      = jstc_pkg::S_SCAN;
                  end
                  jstc_pkg::OP_SWEEP: begin
                     sw_idx_in     = '0;
                     sw_cnt_in     = '0;
                     hold_valid_in = 1'b0;
                     state_in      = jstc_pkg::S_SW_RD;
                  end
                  default: begin
                     state_in = jstc_pkg::S_IDLE;
                  end
               endcase
            end
         end

         // entry is back: write it back, or clear its valid bit on remove; answer
         jstc_pkg::S_RMW: begin
            state_in = jstc_pkg::S_EMIT;
            case (op_ff)
               jstc_pkg::OP_SET_STATE: begin
                  wr_en         = 1'b1;
                  wr_addr       = slot_ff;
                  wr_data       = rd_data;
                  wr_data.state = st_ff;
                  res_in = rsp_ok(rd_data.number, rd_data.group, st_ff, slot_ff);
               end
               jstc_pkg::OP_MARK_RUNNING: begin
                  wr_en         = 1'b1;
                  wr_addr       = slot_ff;
                  wr_data       = rd_data;
                  wr_data.state = jstc_pkg::RUN_RUNNING;
                  cur_valid_in  = 1'b1;
                  cur_slot_in   = slot_ff;
                  res_in = rsp_ok(rd_data.number, rd_data.group, jstc_pkg::RUN_RUNNING,
                                  slot_ff);
               end
               default: begin
                  // remove: answer with the old entry, rescan if it was current
                  valid_in[slot_ff] = 1'b0;
                  res_in = rsp_ok(rd_data.number, rd_data.group, rd_data.state, slot_ff);
                  if (cur_valid_ff && (cur_slot_ff == slot_ff)) begin
                     cur_valid_in  = 1'b0;
                     mode_in       = jstc_pkg::MODE_MAX;
                     scan_cnt_in   = '0;
                     ev_pend_in    = 1'b0;
                     best_valid_in = 1'b0;
                     ret_sweep_in  = 1'b0;
                     after_in      = jstc_pkg::S_SCAN;
                  end else begin
                     after_in = jstc_pkg::S_IDLE;
                  end
               end
            endcase
         end

         // current entry is back from the ram
         jstc_pkg::S_CUR: begin
            if ((op_ff == jstc_pkg::OP_GET_CURRENT) ||
                (rd_data.state == jstc_pkg::RUN_STOPPED)) begin
               res_in   = rsp_ok(rd_data.number, rd_data.group, rd_data.state, cur_slot_ff);
               state_in = jstc_pkg::S_EMIT;
            end else begin
               mode_in       = jstc_pkg::MODE_STOP;
               scan_cnt_in   = '0;
               ev_pend_in    = 1'b0;
               best_valid_in = 1'b0;
               ret_sweep_in  = 1'b0;
               state_in      = jstc_pkg::S_SCAN;
            end
         end

         // one read issued and one entry compared per cycle
         jstc_pkg::S_SCAN: begin
            if (issue_ok) begin
               rd_en       = 1'b1;
               rd_addr     = scan_cnt_ff[SW-1:0];
               ev_pend_in  = 1'b1;
               ev_idx_in   = scan_cnt_ff[SW-1:0];
               scan_cnt_in = scan_cnt_ff + CW'(1);
            end else begin
               ev_pend_in = 1'b0;
            end
            if (ev_pend_ff && ev_hit) begin
               best_valid_in = 1'b1;
               best_idx_in   = ev_idx_ff;
               best_ent_in   = rd_data;
            end
            if (!issue_ok && !ev_pend_ff) begin
               case (mode_ff)
                  jstc_pkg::MODE_STOP: begin
                     state_in = jstc_pkg::S_EMIT;
                     after_in = jstc_pkg::S_IDLE;
                     if (best_valid_ff) begin
                        res_in = rsp_ok(best_ent_ff.number, best_ent_ff.group,
                                        best_ent_ff.state, best_idx_ff);
                     end else begin
                        res_in = rsp_bad(jstc_pkg::STATUS_NONE);
                     end
                  end
                  jstc_pkg::MODE_PID: begin
                     state_in = jstc_pkg::S_EMIT;
                     after_in = jstc_pkg::S_IDLE;
                     if (!best_valid_ff) begin
                        res_in = rsp_bad(jstc_pkg::STATUS_NONE);
                     end else if (!term_ff) begin
                        res_in = rsp_bad(jstc_pkg::STATUS_IGNORED);
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = best_idx_ff;
                        wr_data       = best_ent_ff;
                        wr_data.state = jstc_pkg::RUN_DONE;
                        res_in = rsp_ok(best_ent_ff.number, best_ent_ff.group,
                                        jstc_pkg::RUN_DONE, best_idx_ff);
                     end
                  end
                  default: begin
                     // highest number wins, ties stay with the lowest slot
                     if (best_valid_ff) begin
                        cur_valid_in = 1'b1;
                        cur_slot_in  = best_idx_ff;
                     end
                     state_in = ret_sweep_ff ? jstc_pkg::S_SW_RD : jstc_pkg::S_IDLE;
                  end
               endcase
            end
         end

         // sweep: skip free slots, read used ones, and finish at the table end or the result limit
         jstc_pkg::S_SW_RD: begin
            if ((sw_idx_ff == SLOT_END) || (sw_cnt_ff == jstc_pkg::MAX_OUT)) begin
               if (!hold_valid_ff) begin
                  res_in = rsp_bad(jstc_pkg::STATUS_NONE);
               end
               hold_valid_in = 1'b0;
               after_in      = jstc_pkg::S_IDLE;
               state_in      = jstc_pkg::S_EMIT;
            end else if (!valid_ff[sw_idx_ff[SW-1:0]]) begin
               sw_idx_in = sw_idx_ff + CW'(1);
            end else begin
               rd_en    = 1'b1;
               rd_addr  = sw_idx_ff[SW-1:0];
               state_in = jstc_pkg::S_SW_EV;
            end
         end

         // sweep: a done job is held back one word so the last one can be marked
         jstc_pkg::S_SW_EV: begin
            if (rd_data.state != jstc_pkg::RUN_DONE) begin
               sw_idx_in = sw_idx_ff + CW'(1);
               state_in  = jstc_pkg::S_SW_RD;
            end else if (!hold_valid_ff || out_free) begin
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = res_ff;
                  rsp_last_in  = 1'b0;
               end
               res_in = rsp_ok(rd_data.number, rd_data.group, rd_data.state,
                               sw_idx_ff[SW-1:0]);
               hold_valid_in                = 1'b1;
               sw_cnt_in                    = sw_cnt_ff +
                                              {{(jstc_pkg::SWEEP_CNT_W-1){1'b0}}, 1'b1};
               valid_in[sw_idx_ff[SW-1:0]]  = 1'b0;
               sw_idx_in                    = sw_idx_ff + CW'(1);
               if (cur_valid_ff && (cur_slot_ff == sw_idx_ff[SW-1:0])) begin
                  cur_valid_in  = 1'b0;
                  mode_in       = jstc_pkg::MODE_MAX;
                  scan_cnt_in   = '0;
                  ev_pend_in    = 1'b0;
                  best_valid_in = 1'b0;
                  ret_sweep_in  = 1'b1;
                  state_in      = jstc_pkg::S_SCAN;
               end else begin
                  state_in = jstc_pkg::S_SW_RD;
               end
            end
         end

         // final word of the command
         jstc_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               rsp_last_in  = 1'b1;
               state_in     = after_ff;
            end
         end

         default: begin
            state_in = jstc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= jstc_pkg::S_IDLE;
         valid_ff       <= '0;
         cur_valid_ff   <= 1'b0;
         next_number_ff <= 32'd1;
         ev_pend_ff     <= 1'b0;
         hold_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         valid_ff       <= valid_in;
         cur_valid_ff   <= cur_valid_in;
         next_number_ff <= next_number_in;
         ev_pend_ff     <= ev_pend_in;
         hold_valid_ff  <= hold_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      after_ff      <= after_in;
      op_ff         <= op_in;
      pid_ff        <= pid_in;
      st_ff         <= st_in;
      term_ff       <= term_in;
      slot_ff       <= slot_in;
      cur_slot_ff   <= cur_slot_in;
      mode_ff       <= mode_in;
      scan_cnt_ff   <= scan_cnt_in;
      ev_idx_ff     <= ev_idx_in;
      best_valid_ff <= best_valid_in;
      best_idx_ff   <= best_idx_in;
      best_ent_ff   <= best_ent_in;
      ret_sweep_ff  <= ret_sweep_in;
      sw_idx_ff     <= sw_idx_in;
      sw_cnt_ff     <= sw_cnt_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_job_number = rsp_ff.number;
   assign rsp_group_out  = rsp_ff.group;
   assign rsp_state_out  = rsp_ff.state;
   assign rsp_slot_out   = rsp_ff.slot;
   assign rsp_last       = rsp_last_ff;

   // the current mark only ever points at a used slot
   a_cur_is_valid: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> valid_ff[cur_slot_ff])
      else $error("current mark on a free slot");

   // every taken command leaves the sequencer busy in the cycle after
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != jstc_pkg::S_IDLE))
      else $error("command taken without leaving idle");

   // a sweep never frees more jobs than it may report
   a_sweep_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == jstc_pkg::S_SW_EV) |-> (sw_cnt_ff < jstc_pkg::MAX_OUT))
      else $error("sweep past its result limit");

   // job numbering never wraps to zero
   a_number_nonzero: assert property (@(posedge clock) disable iff (reset)
      (next_number_ff != 32'd0) && ($past(next_number_ff) <= next_number_ff))
      else $error("job number counter wrapped");

endmodule
